// ===== hdl/bnv_pkg.sv =====
`timescale 1ns / 1ps

package bnv_pkg;

   // Name kinds carried with every character
   typedef enum logic [1:0] {
      MODE_MEMBER    = 2'd0,
      MODE_INTERFACE = 2'd1,
      MODE_UNIQUE    = 2'd2,
      MODE_BAD       = 2'd3
   } mode_type;

   localparam int unsigned CH_W  = 8;
   localparam int unsigned POS_W = 9;

   localparam logic [CH_W-1:0]  CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0]  CH_COLON = 8'h3A;
   localparam logic [CH_W-1:0]  CH_DOT   = 8'h2E;
   localparam logic [POS_W-1:0] POS_SAT  = 9'd511;
   localparam logic [POS_W-1:0] MAX_LEN  = 9'd255;

   // Running state of the name being scanned
   typedef struct packed {
      logic [POS_W-1:0] char_position;
      logic             at_segment_start;
      logic             seen_dot;
      logic             failed;
   } scan_type;

   localparam scan_type SCAN_RESET = '{
      char_position:    '0,
      at_segment_start: 1'b1,
      seen_dot:         1'b0,
      failed:           1'b0
   };

endpackage

// ===== hdl/bnv_step.sv =====
`timescale 1ns / 1ps

// Per-character rule check and the verdict on the terminator.
module bnv_step import bnv_pkg::*; (
   input  scan_type         cur,
   input  logic [CH_W-1:0]  ch,
   input  logic [1:0]       mode,
   output scan_type         nxt,
   output logic             verdict
);

   logic word_char;
   logic digit_char;
   logic body_ok;
   logic dot_ok;
   logic dots_allowed;

   // Classify the character
   always_comb begin
      word_char  = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)
                   || (ch == 8'h5F);
      digit_char = (ch >= 8'h30 && ch <= 8'h39);
      body_ok    = word_char || (!cur.at_segment_start && digit_char);
      dots_allowed = (mode == MODE_INTERFACE) || (mode == MODE_UNIQUE);
      dot_ok     = dots_allowed && !cur.at_segment_start && (ch == CH_DOT);
   end

   // Advance the scan state for a non-terminator character
   always_comb begin
      nxt = cur;
      case (mode_type'(mode))
         MODE_MEMBER, MODE_INTERFACE: begin
            if (body_ok) begin
               nxt.at_segment_start = 1'b0;
            end else if (dot_ok) begin
               nxt.at_segment_start = 1'b1;
               nxt.seen_dot         = 1'b1;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         MODE_UNIQUE: begin
            if (cur.char_position == '0) begin
               if (ch != CH_COLON) begin
                  nxt.failed = 1'b1;
               end
            end else if (body_ok) begin
               nxt.at_segment_start = 1'b0;
            end else if (dot_ok) begin
               nxt.at_segment_start = 1'b1;
               nxt.seen_dot         = 1'b1;
            end else begin
               nxt.failed = 1'b1;
            end
         end
         default: begin
            nxt.failed = 1'b1;
         end
      endcase
      if (cur.char_position != POS_SAT) begin
         nxt.char_position = cur.char_position + 1'b1;
      end
   end

   // Verdict under the mode given with the terminator
   always_comb begin
      case (mode_type'(mode))
         MODE_MEMBER: begin
            verdict = !cur.failed && (cur.char_position != '0)
                      && (cur.char_position <= MAX_LEN);
         end
         MODE_INTERFACE: begin
            verdict = !cur.failed && !cur.at_segment_start && cur.seen_dot
                      && (cur.char_position <= MAX_LEN);
         end
         MODE_UNIQUE: begin
            verdict = !cur.failed && (cur.char_position != '0)
                      && !cur.at_segment_start && cur.seen_dot
                      && (cur.char_position <= MAX_LEN);
         end
         default: begin
            verdict = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/bus_name_validator_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (low bit up)                 Transfers
// req_      in         ch[7:0], mode[9:8], zero pad [15:10]      one per character
// rsp_      out        valid_res[0], name_length[9:1], pad       one per NUL terminator
//
// One character is taken every cycle unless a terminator waits on a stalled result;
// an input register and the result register bound a single pass through the class
// decode and flag update. A terminator's result passes through the input register
// and then the result register, once the result register is free.
// Synchronous reset clears the scan state and both valid flags.
// A stalled result holds only terminators: other characters keep flowing until one arrives.
module bus_name_validator_unit import bnv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ch[7:0], mode[9:8], zero [15:10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // valid_res[0], name_length[9:1], zero [15:10]
);

   logic             in_valid_ff, in_valid_in;
   logic [CH_W-1:0]  in_ch_ff;
   logic [1:0]       in_mode_ff;
   scan_type         scan_ff, scan_in;
   scan_type         scan_step;
   logic             verdict;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_res_ff;
   logic [POS_W-1:0] rsp_len_ff;
   logic             is_term;
   logic             advance;

   bnv_step u_step (
      .cur     (scan_ff),
      .ch      (in_ch_ff),
      .mode    (in_mode_ff),
      .nxt     (scan_step),
      .verdict (verdict)
   );

   // Move the held character on unless it is a terminator facing a full result
   always_comb begin
      is_term     = (in_ch_ff == CH_NUL);
      advance     = in_valid_ff && (!is_term || !rsp_valid_ff || rsp_tready);
      req_tready  = !in_valid_ff || advance;
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      scan_in     = scan_ff;
      if (advance) begin
         scan_in = is_term ? SCAN_RESET : scan_step;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && is_term) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= SCAN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
      end
   end

   // Capture input payload on transfer
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff   <= req_tdata[7:0];
         in_mode_ff <= req_tdata[9:8];
      end
   end

   // Load the result on a terminator
   always_ff @(posedge clock) begin
      if (advance && is_term) begin
         rsp_res_ff <= verdict;
         rsp_len_ff <= scan_ff.char_position;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_len_ff, rsp_res_ff};

endmodule

// ===== hdl/bnv_checker.sv =====
`timescale 1ns / 1ps

module bnv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // An accepted verdict never passes an empty or over-long name
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[9:1] != 9'd0 && rsp_tdata[9:1] <= 9'd255)
      else $error("pass verdict with bad length");

   // A terminator taken while no result waits shows a result through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[7:0] == 8'h00 && !rsp_tvalid
      |=> ##1 rsp_tvalid)
      else $error("terminator produced no result");

endmodule

bind bus_name_validator_unit bnv_checker u_bnv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
